// File: rtl/bmp_dec_pkg.sv
// Shared types and constants for the BMP stream pixel decoder.
// Holds the beat structs, the phase and status enums and header byte offsets; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmp_dec_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;

  localparam int unsigned WidthW  = $clog2(MaxWidth + 1);
  localparam int unsigned HeightW = $clog2(MaxHeight + 1);
  localparam int unsigned IndexW  = 24;
  localparam int unsigned PosW    = 32;

  // Byte positions within the 54-byte header
  localparam logic [PosW-1:0] PosSigEnd    = 32'd1;
  localparam logic [PosW-1:0] PosOffsetEnd = 32'd13;
  localparam logic [PosW-1:0] PosWidthEnd  = 32'd21;
  localparam logic [PosW-1:0] PosHeightEnd = 32'd25;
  localparam logic [PosW-1:0] PosDepthEnd  = 32'd29;
  localparam logic [PosW-1:0] PosHdrEnd    = 32'd53;
  localparam logic [PosW-1:0] HdrBytes     = 32'd54;

  localparam logic [15:0] Signature = 16'h4D42;
  localparam logic [15:0] Depth24   = 16'd24;
  localparam logic [15:0] Depth32   = 16'd32;
  localparam logic [7:0]  OpaqueAlpha = 8'hFF;
  localparam logic [1:0]  AlphaByte   = 2'd3;
  localparam logic [1:0]  LastRgbByte = 2'd2;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_SKIP   = 5'b00010,
    PH_PIXELS = 5'b00100,
    PH_PAD    = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    ST_PIXEL     = 2'd0,
    ST_BAD_SIG   = 2'd1,
    ST_BAD_DEPTH = 2'd2,
    ST_BAD_SIZE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_beat_t;

  typedef struct packed {
    logic [31:0]       color;
    logic [IndexW-1:0] pixel_index;
    status_e           status;
    logic              last;
  } out_beat_t;

endpackage

`default_nettype wire

// File: rtl/bmp_stream_pixel_decoder.sv
// BMP stream pixel decoder: one file byte per beat in, ARGB pixels with index out.
// Each result is registered and presented in the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle; input stalls only while a held result is not taken.
// Reset: asynchronous, active low; clears the parser to the header phase, no clearing pass.
// Depends on bmp_dec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmp_stream_pixel_decoder (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire bmp_dec_pkg::in_beat_t  in_data_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output bmp_dec_pkg::out_beat_t      out_data_o
);
  import bmp_dec_pkg::*;

  phase_e              phase_q, phase_d, phase_c;
  logic [PosW-1:0]     pos_q, pos_d, pos_c;
  logic [31:0]         shift_q, shift_d, shift_c;
  logic [31:0]         offset_q, offset_d, offset_c;
  logic [WidthW-1:0]   width_q, width_d, width_c;
  logic [HeightW-1:0]  height_q, height_d, height_c;
  logic                bottom_up_q, bottom_up_d, bottom_up_c;
  logic                has_alpha_q, has_alpha_d, has_alpha_c;
  logic [1:0]          bip_q, bip_d, bip_c;
  logic [23:0]         cbytes_q, cbytes_d, cbytes_c;
  logic [WidthW-1:0]   column_q, column_d, column_c;
  logic [HeightW-1:0]  rows_q, rows_d, rows_c;
  logic [1:0]          pad_q, pad_d, pad_c;
  logic [IndexW-1:0]   row_base_q, row_base_d, row_base_c;
  logic                size_bad_q, size_bad_d, size_bad_c;

  logic                out_valid_q;
  out_beat_t           out_data_q;
  logic                emit;
  out_beat_t           result;

  logic                in_fire;
  logic                sof;
  logic [7:0]          b;
  logic [31:0]         shift_n;
  logic [31:0]         height_mag;
  logic [IndexW-1:0]   height_ext, width_ext, column_ext;
  logic [IndexW-1:0]   base_prod;
  logic [WidthW-1:0]   col_inc;
  logic [HeightW-1:0]  rows_inc;
  logic [1:0]          pad_next;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign sof = in_data_i.start_of_file;
  assign b   = in_data_i.data_byte;

  // Start of file restarts the parser before this byte is taken as byte 0
  always_comb begin
    phase_c     = sof ? PH_HEADER : phase_q;
    pos_c       = sof ? '0 : pos_q;
    shift_c     = sof ? '0 : shift_q;
    offset_c    = sof ? '0 : offset_q;
    width_c     = sof ? '0 : width_q;
    height_c    = sof ? '0 : height_q;
    bottom_up_c = sof ? 1'b0 : bottom_up_q;
    has_alpha_c = sof ? 1'b0 : has_alpha_q;
    bip_c       = sof ? '0 : bip_q;
    cbytes_c    = sof ? '0 : cbytes_q;
    column_c    = sof ? '0 : column_q;
    rows_c      = sof ? '0 : rows_q;
    pad_c       = sof ? '0 : pad_q;
    row_base_c  = sof ? '0 : row_base_q;
    size_bad_c  = sof ? 1'b0 : size_bad_q;
  end

  assign shift_n    = {b, shift_c[31:8]};
  assign height_mag = shift_n[31] ? (~shift_n + 32'd1) : shift_n;
  assign height_ext = IndexW'(height_c) - IndexW'(1);
  assign width_ext  = IndexW'(width_c);
  assign column_ext = IndexW'(column_c);
  assign base_prod  = height_ext * width_ext;
  assign col_inc    = column_c + WidthW'(1);
  assign rows_inc   = rows_c + HeightW'(1);
  // Row padding: 3*width mod 4 is set by the low two width bits
  assign pad_next   = 2'(3'd4 - 3'(2'(width_c[1:0] * 2'd3)));

  always_comb begin
    phase_d     = phase_c;
    pos_d       = pos_c + PosW'(1);
    shift_d     = shift_c;
    offset_d    = offset_c;
    width_d     = width_c;
    height_d    = height_c;
    bottom_up_d = bottom_up_c;
    has_alpha_d = has_alpha_c;
    bip_d       = bip_c;
    cbytes_d    = cbytes_c;
    column_d    = column_c;
    rows_d      = rows_c;
    pad_d       = pad_c;
    row_base_d  = row_base_c;
    size_bad_d  = size_bad_c;
    emit        = 1'b0;
    result      = '{color: '0, pixel_index: '0, status: ST_PIXEL, last: 1'b0};

    case (phase_c)
      PH_HEADER: begin
        shift_d = shift_n;
        if (pos_c == PosSigEnd && shift_n[31:16] != Signature) begin
          phase_d = PH_DONE;
          emit    = 1'b1;
          result  = '{color: '0, pixel_index: '0, status: ST_BAD_SIG, last: 1'b1};
        end
        if (pos_c == PosOffsetEnd) begin
          offset_d = shift_n;
        end
        if (pos_c == PosWidthEnd) begin
          if (shift_n[31] || shift_n == '0 || shift_n > 32'(MaxWidth)) begin
            size_bad_d = 1'b1;
          end else begin
            width_d = shift_n[WidthW-1:0];
          end
        end
        if (pos_c == PosHeightEnd) begin
          bottom_up_d = !shift_n[31];
          if (height_mag == '0 || height_mag > 32'(MaxHeight)) begin
            size_bad_d = 1'b1;
          end else begin
            height_d = height_mag[HeightW-1:0];
          end
        end
        if (pos_c == PosDepthEnd) begin
          if (shift_n[31:16] != Depth24 && shift_n[31:16] != Depth32) begin
            phase_d = PH_DONE;
            emit    = 1'b1;
            result  = '{color: '0, pixel_index: '0, status: ST_BAD_DEPTH, last: 1'b1};
          end else begin
            has_alpha_d = (shift_n[31:16] == Depth32);
          end
        end
        if (pos_c == PosHdrEnd) begin
          if (size_bad_c || offset_c < HdrBytes) begin
            phase_d = PH_DONE;
            emit    = 1'b1;
            result  = '{color: '0, pixel_index: '0, status: ST_BAD_SIZE, last: 1'b1};
          end else begin
            row_base_d = bottom_up_c ? base_prod : '0;
            phase_d    = (offset_c == HdrBytes) ? PH_PIXELS : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (pos_d == offset_c) begin
          phase_d = PH_PIXELS;
        end
      end
      PH_PAD: begin
        pad_d = pad_c - 2'd1;
        if (pad_c == 2'd1) begin
          phase_d = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        if (bip_c != AlphaByte) begin
          cbytes_d[bip_c*8 +: 8] = b;
        end
        if (bip_c != (has_alpha_c ? AlphaByte : LastRgbByte)) begin
          bip_d = bip_c + 2'd1;
        end else begin
          emit               = 1'b1;
          result.color       = {has_alpha_c ? b : OpaqueAlpha, cbytes_d};
          result.pixel_index = row_base_c + column_ext;
          bip_d              = '0;
          cbytes_d           = '0;
          column_d           = col_inc;
          if (col_inc >= width_c) begin
            column_d = '0;
            rows_d   = rows_inc;
            if (rows_inc >= height_c) begin
              result.last = 1'b1;
              phase_d     = PH_DONE;
            end else begin
              row_base_d = bottom_up_c ? row_base_c - width_ext : row_base_c + width_ext;
              pad_d      = has_alpha_c ? 2'd0 : pad_next;
              if (!has_alpha_c && pad_next != 2'd0) begin
                phase_d = PH_PAD;
              end
            end
          end
        end
      end
      PH_DONE: begin
        // drop bytes until the next start of file
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      pos_q       <= '0;
      shift_q     <= '0;
      offset_q    <= '0;
      width_q     <= '0;
      height_q    <= '0;
      bottom_up_q <= 1'b0;
      has_alpha_q <= 1'b0;
      bip_q       <= '0;
      cbytes_q    <= '0;
      column_q    <= '0;
      rows_q      <= '0;
      pad_q       <= '0;
      row_base_q  <= '0;
      size_bad_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        shift_q     <= shift_d;
        offset_q    <= offset_d;
        width_q     <= width_d;
        height_q    <= height_d;
        bottom_up_q <= bottom_up_d;
        has_alpha_q <= has_alpha_d;
        bip_q       <= bip_d;
        cbytes_q    <= cbytes_d;
        column_q    <= column_d;
        rows_q      <= rows_d;
        pad_q       <= pad_d;
        row_base_q  <= row_base_d;
        size_bad_q  <= size_bad_d;
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load only when a beat produces a result
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_data_q <= result;
    end
  end

endmodule

`default_nettype wire

// File: bench/tb_bmp_stream_pixel_decoder.sv
// Self-checking bench for bmp_stream_pixel_decoder: byte-level BMP files in, ARGB pixels out.
// Depends on bmp_dec_pkg and the decoder RTL; predicts every pixel and error beat in-line.
`timescale 1ns / 1ps

module tb_bmp_stream_pixel_decoder;
  import bmp_dec_pkg::*;

  typedef struct packed {
    in_beat_t beat;
    logic     drain;  // hold this byte back until every pending result has arrived
  } file_byte_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_beat;

  file_byte_t pending_bytes[$];
  out_beat_t  expected_pixels[$];
  file_byte_t launch_byte;
  out_beat_t  oldest_pixel;
  int         fail_count = 0;
  int         results_seen = 0;
  int         stall_left = 0;
  int         cycle_no = 0;
  logic       calm;

  // Decoder state mirror
  phase_e             dec_phase;
  logic [PosW-1:0]    dec_pos, dec_shift, dec_offset;
  logic [WidthW-1:0]  dec_width, dec_column;
  logic [HeightW-1:0] dec_height, dec_rows;
  logic               dec_bottom_up, dec_alpha, dec_size_bad;
  logic [1:0]         dec_byte_no, dec_pad;
  logic [23:0]        dec_rgb;
  logic [IndexW-1:0]  dec_row_base;

  bmp_stream_pixel_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_beat)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_no <= cycle_no + 1;
  assign calm = (cycle_no >= 1500) && (cycle_no < 6000);

  task automatic restart_decoder();
    dec_phase     = PH_HEADER;
    dec_pos       = '0;
    dec_shift     = '0;
    dec_offset    = '0;
    dec_width     = '0;
    dec_height    = '0;
    dec_bottom_up = 1'b0;
    dec_alpha     = 1'b0;
    dec_byte_no   = '0;
    dec_rgb       = '0;
    dec_column    = '0;
    dec_rows      = '0;
    dec_pad       = '0;
    dec_row_base  = '0;
    dec_size_bad  = 1'b0;
  endtask

  task automatic flag_error(input status_e st);
    dec_phase = PH_DONE;
    expected_pixels.push_back('{color: '0, pixel_index: '0, status: st, last: 1'b1});
  endtask

  task automatic decode_byte(input in_beat_t beat);
    logic [PosW-1:0] pos, mag;
    logic [15:0]     depth;
    logic [2:0]      count, nbytes;
    logic [31:0]     color;
    logic [IndexW-1:0] index;
    logic            end_of_image;
    if (beat.start_of_file) restart_decoder();
    pos = dec_pos;
    dec_pos = pos + 1;
    case (dec_phase)
      PH_HEADER: begin
        dec_shift = {beat.data_byte, dec_shift[31:8]};
        case (pos)
          PosSigEnd: if (dec_shift[31:16] != Signature) flag_error(ST_BAD_SIG);
          PosOffsetEnd: dec_offset = dec_shift;
          PosWidthEnd: begin
            if (dec_shift[31] || dec_shift == 0 || dec_shift > MaxWidth) dec_size_bad = 1'b1;
            else dec_width = dec_shift[WidthW-1:0];
          end
          PosHeightEnd: begin
            mag = dec_shift[31] ? (~dec_shift + 1) : dec_shift;
            dec_bottom_up = !dec_shift[31];
            if (mag == 0 || mag > MaxHeight) dec_size_bad = 1'b1;
            else dec_height = mag[HeightW-1:0];
          end
          PosDepthEnd: begin
            depth = dec_shift[31:16];
            if (depth != Depth24 && depth != Depth32) flag_error(ST_BAD_DEPTH);
            else dec_alpha = (depth == Depth32);
          end
          PosHdrEnd: begin
            if (dec_size_bad || dec_offset < HdrBytes) begin
              flag_error(ST_BAD_SIZE);
            end else begin
              dec_row_base = dec_bottom_up ?
                  (IndexW'(dec_height) - 1) * IndexW'(dec_width) : '0;
              dec_phase = (dec_offset == HdrBytes) ? PH_PIXELS : PH_SKIP;
            end
          end
          default: ;
        endcase
      end
      PH_SKIP: if (pos + 1 == dec_offset) dec_phase = PH_PIXELS;
      PH_PAD: begin
        if (dec_pad != 0) dec_pad = dec_pad - 2'd1;
        if (dec_pad == 0) dec_phase = PH_PIXELS;
      end
      PH_PIXELS: begin
        if (dec_byte_no != AlphaByte)
          dec_rgb = dec_rgb | (24'(beat.data_byte) << (8 * dec_byte_no));
        count  = {1'b0, dec_byte_no} + 3'd1;
        nbytes = dec_alpha ? 3'd4 : 3'd3;
        if (count < nbytes) begin
          dec_byte_no = count[1:0];
        end else begin
          color = {(dec_alpha ? beat.data_byte : OpaqueAlpha), dec_rgb};
          index = dec_row_base + IndexW'(dec_column);
          end_of_image = 1'b0;
          dec_byte_no = '0;
          dec_rgb = '0;
          dec_column = dec_column + 1;
          if (dec_column >= dec_width) begin
            dec_column = '0;
            dec_rows = dec_rows + 1;
            if (dec_rows >= dec_height) begin
              end_of_image = 1'b1;
              dec_phase = PH_DONE;
            end else begin
              if (dec_bottom_up) dec_row_base = dec_row_base - IndexW'(dec_width);
              else dec_row_base = dec_row_base + IndexW'(dec_width);
              // 24-bit rows pad to a 4-byte boundary
              dec_pad = dec_alpha ? 2'd0 : 2'd0 - 2'(dec_width[1:0] * 2'd3);
              if (dec_pad != 0) dec_phase = PH_PAD;
            end
          end
          expected_pixels.push_back('{color: color, pixel_index: index, status: ST_PIXEL,
                                      last: end_of_image});
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic sof, input logic drain);
    pending_bytes.push_back('{beat: '{data_byte: b, start_of_file: sof}, drain: drain});
  endtask

  // Build one file; a good header gets a full pixel body, a bad one a few junk bytes
  task automatic queue_file(input logic [31:0] wid, input logic [31:0] hgt,
                            input logic [15:0] bpp, input logic [31:0] offset,
                            input logic [15:0] sig, input bit good, input bit sof_first,
                            input bit drain);
    logic [7:0] hdr [0:53];
    int rows, per_row, pad;
    for (int i = 0; i < 54; i++) hdr[i] = 8'($urandom);
    {hdr[1], hdr[0]} = sig;
    {hdr[13], hdr[12], hdr[11], hdr[10]} = offset;
    {hdr[21], hdr[20], hdr[19], hdr[18]} = wid;
    {hdr[25], hdr[24], hdr[23], hdr[22]} = hgt;
    {hdr[29], hdr[28]} = bpp;
    push_byte(hdr[0], sof_first, drain);
    for (int i = 1; i < 54; i++) push_byte(hdr[i], 1'b0, 1'b0);
    if (!good) begin
      repeat ($urandom_range(8)) push_byte(8'($urandom), 1'b0, 1'b0);
    end else begin
      rows    = hgt[31] ? int'(-hgt) : int'(hgt);
      per_row = int'(wid) * int'(bpp / 8);
      pad     = (bpp == Depth32) ? 0 : (4 - (int'(wid) * 3) % 4) % 4;
      repeat (int'(offset) - 54) push_byte(8'($urandom), 1'b0, 1'b0);
      for (int r = 0; r < rows; r++) begin
        repeat (per_row) push_byte(8'($urandom), 1'b0, 1'b0);
        if (r < rows - 1) repeat (pad) push_byte(8'($urandom), 1'b0, 1'b0);
      end
    end
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
  endtask

  // Byte driver: predict on each accepted beat, then offer the next one
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) decode_byte(in_beat);
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 &&
            !(pending_bytes[0].drain && expected_pixels.size() != 0) &&
            (calm || $urandom_range(99) >= 16)) begin
          launch_byte = pending_bytes.pop_front();
          in_beat  <= launch_byte.beat;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor: compare each taken beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          $display({"%0t: unexpected result, expected none actual color %h index %h",
                    " status %0d last %b"},
                   $time, out_beat.color, out_beat.pixel_index, out_beat.status, out_beat.last);
        end else begin
          oldest_pixel = expected_pixels.pop_front();
          if (out_beat.color !== oldest_pixel.color)
            report_field("color", oldest_pixel.color, out_beat.color);
          if (out_beat.pixel_index !== oldest_pixel.pixel_index)
            report_field("pixel_index", 32'(oldest_pixel.pixel_index),
                         32'(out_beat.pixel_index));
          if (out_beat.status !== oldest_pixel.status)
            report_field("status", 32'(oldest_pixel.status), 32'(out_beat.status));
          if (out_beat.last !== oldest_pixel.last)
            report_field("last", 32'(oldest_pixel.last), 32'(out_beat.last));
        end
        results_seen++;
        // back-pressure long enough to fill the block and stall its input
        if (results_seen == 30) stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  initial begin : stimulus
    int kind, w, h, off, mark, byte_goal;
    logic [15:0] bpp;
    logic [31:0] hv;
    bit drain;
    restart_decoder();

    // Directed files
    queue_file(3, 2, 24, 54, Signature, 1, 0, 0);           // no start flag after reset, pad 3
    queue_file(2, -2, 32, 58, Signature, 1, 1, 0);          // top-down, skip to offset
    queue_file(1, 3, 24, 55, Signature, 1, 1, 0);           // pad 1
    queue_file(2, -2, 24, 54, Signature, 1, 1, 0);          // pad 2
    mark = pending_bytes.size();
    queue_file(2, 2, 24, 54, 16'h4D43, 0, 1, 0);            // signature low byte wrong
    while (pending_bytes.size() > mark + 4) void'(pending_bytes.pop_back());
    mark = pending_bytes.size();
    queue_file(2, 2, 24, 54, 16'hCD42, 0, 1, 0);            // signature high byte wrong
    while (pending_bytes.size() > mark + 4) void'(pending_bytes.pop_back());
    mark = pending_bytes.size();
    queue_file(2, 2, 16, 54, Signature, 0, 1, 0);           // unsupported depth
    while (pending_bytes.size() > mark + 32) void'(pending_bytes.pop_back());
    queue_file(0, 0, 8, 40, Signature, 0, 1, 0);            // depth wins over size
    queue_file(0, 0, 8, 40, 16'h0000, 0, 1, 0);             // signature wins over all
    queue_file(0, 1, 24, 54, Signature, 0, 1, 0);           // zero width
    queue_file(4097, 1, 24, 54, Signature, 0, 1, 0);        // width above max
    queue_file(32'hFFFF_FFFF, 1, 32, 54, Signature, 0, 1, 0); // negative width
    queue_file(1, 0, 24, 54, Signature, 0, 1, 0);           // zero height
    queue_file(1, 4097, 24, 54, Signature, 0, 1, 0);        // height above max
    queue_file(1, -4097, 24, 54, Signature, 0, 1, 0);       // top-down height above max
    queue_file(1, 1, 24, 53, Signature, 0, 1, 0);           // offset inside header
    queue_file(1, 1, 24, 0, Signature, 0, 1, 0);            // zero offset
    mark = pending_bytes.size();
    queue_file(4, 3, 24, 54, Signature, 1, 1, 0);
    repeat (10) void'(pending_bytes.pop_back());            // restart in the middle of pixels
    mark = pending_bytes.size();
    queue_file(3, 3, 32, 54, Signature, 1, 1, 0);
    while (pending_bytes.size() > mark + 20) void'(pending_bytes.pop_back()); // mid-header
    queue_file(5, -3, 24, 56, Signature, 1, 1, 1);          // sender waits for drain
    // Largest sizes: keep the header and the first few pixels only
    mark = pending_bytes.size();
    queue_file(4096, 1, 24, 54, Signature, 1, 1, 0);        // widest image
    while (pending_bytes.size() > mark + 63) void'(pending_bytes.pop_back());
    mark = pending_bytes.size();
    queue_file(1, -4096, 32, 54, Signature, 1, 1, 1);       // tallest top-down image
    while (pending_bytes.size() > mark + 62) void'(pending_bytes.pop_back());
    mark = pending_bytes.size();
    queue_file(1, 4096, 32, 54, Signature, 1, 1, 0);        // tallest bottom-up image
    while (pending_bytes.size() > mark + 62) void'(pending_bytes.pop_back());

    // Random files, mostly well formed
    byte_goal = pending_bytes.size() + 200;
    while (pending_bytes.size() < byte_goal) begin
      kind  = $urandom_range(99);
      w     = $urandom_range(1, 6);
      h     = $urandom_range(1, 4);
      bpp   = $urandom_range(1) ? Depth32 : Depth24;
      off   = 54 + (($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0);
      hv    = $urandom_range(1) ? 32'(-h) : 32'(h);
      drain = ($urandom_range(11) == 0);
      if (kind < 72) begin
        queue_file(w, hv, bpp, off, Signature, 1, 1, drain);
      end else if (kind < 80) begin
        queue_file(w, hv, bpp, off, Signature, 1, 1, drain);
        repeat ($urandom_range(1, 40)) void'(pending_bytes.pop_back());
      end else if (kind < 92) begin
        case ($urandom_range(4))
          0: queue_file(w, hv, bpp, off, 16'($urandom), 0, 1, drain);
          1: queue_file(w, hv, 16'($urandom), off, Signature, 0, 1, drain);
          2: queue_file($urandom_range(1) ? $urandom : 4097, hv, bpp, off, Signature, 0, 1,
                        drain);
          3: queue_file(w, $urandom_range(1) ? $urandom : 0, bpp, off, Signature, 0, 1, drain);
          default: queue_file(w, hv, bpp, $urandom_range(53), Signature, 0, 1, drain);
        endcase
      end else begin
        repeat ($urandom_range(5, 20))
          push_byte(8'($urandom), ($urandom_range(7) == 0), 1'b0);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    for (int n = 0; n < 200000 && expected_pixels.size() != 0; n++) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results missing, oldest expected color %h index %h actual none",
               $time, expected_pixels.size(), expected_pixels[0].color,
               expected_pixels[0].pixel_index);
    end
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("** bmp_stream_pixel_decoder: PASSED **");
    end else begin
      $display("** bmp_stream_pixel_decoder: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** bmp_stream_pixel_decoder: FAILED **");
    $finish;
  end

endmodule

// File: bmp_stream_pixel_decoder.f
rtl/bmp_dec_pkg.sv
rtl/bmp_stream_pixel_decoder.sv
bench/tb_bmp_stream_pixel_decoder.sv
